/* rtl/cops_pkg.sv */
`default_nettype none
package cops_pkg;

    localparam int PhaseBits   = 32;
    localparam int CordicSteps = 32;
    localparam int StepBits    = $clog2(CordicSteps);
    localparam int DivBits     = $clog2(PhaseBits + 1);

    localparam logic [28:0] Kq2000Pi   = 29'd411774832;
    localparam logic [63:0] CordicGain = 64'd2800459870029452954;
    localparam logic [63:0] PiHalfQ62  = 64'h6487ED5110B4611A;
    localparam logic [63:0] PiQtrQ62   = 64'h3243F6A8885A308D;
    localparam logic [39:0] Mask40     = 40'hFF_FFFF_FFFF;

    localparam logic [1:0] CfgRadius = 2'd0;
    localparam logic [1:0] CfgSpeed  = 2'd1;
    localparam logic [1:0] CfgScale  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_D,
        S_MUL_B,
        S_CHECK,
        S_DIV,
        S_ACC,
        S_ZMUL,
        S_CORDIC,
        S_QUAD,
        S_SCALE_X,
        S_SCALE_Y,
        S_OUT
    } t_state;

    typedef logic [CordicSteps-1:0][63:0] t_atan_tab;

    function automatic logic [63:0] atan_q62(input logic [5:0] i);
        logic [63:0] sum;
        logic [63:0] t;
        int          n;
        sum = 64'd0;
        if (i == 6'd0) begin
            sum = PiQtrQ62;
        end else begin
            for (int k = 0; k < 32; k++) begin
                n = (2 * k + 1) * int'(i);
                if (n <= 62) begin
                    t = (64'd1 << (62 - n)) / 64'((2 * k + 1));
                    if (k % 2 == 1) sum = sum - t;
                    else sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    function automatic t_atan_tab atan_table();
        t_atan_tab tab;
        for (int i = 0; i < CordicSteps; i++) begin
            tab[i] = atan_q62(6'(i));
        end
        return tab;
    endfunction

    localparam t_atan_tab AtanTab = atan_table();

endpackage
`default_nettype wire

/* rtl/circular_orbit_position_step_top.sv */
`default_nettype none
// Channel  Direction  Handshake          Payload
// cfg      in         i_cfg_valid/ready  i_cfg_index (0 radius, 1 speed, 2 scale), i_cfg_data
// s_axis   in         tvalid/tready      tdata[15:0] time_interval_ms
// m_axis   out        tvalid/tready      tdata: pos_x, pos_y, orbit_count, step_clamped
// Six 64x64 products share one 32x32 multiplier, which forms their partial products in
// turn; the step divide runs 32 steps (skipped when clamped), the CORDIC 32 rotations,
// and the result is held on m_axis until it is taken.
// Reset is synchronous, active low; it restores the register defaults and clears the phase.
// s_axis_tready is low from acceptance until the result has been taken on m_axis.
module circular_orbit_position_step_top
    import cops_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [39:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [15:0]  s_axis_tdata,   // [15:0] time_interval_ms
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [119:0]      m_axis_tdata    // [40:0] pos_x, [81:41] pos_y,
                                              // [113:82] orbit_count, [114] step_clamped
);

    t_state r_state, n_state;

    logic [39:0] r_radius;
    logic [19:0] r_speed;
    logic [23:0] r_scale;
    logic [PhaseBits-1:0] r_phase;
    logic [31:0] r_orbits;

    logic [15:0]  r_dt;
    logic [63:0]  r_prod;
    logic [127:0] r_rem;
    logic [127:0] r_den;
    logic [PhaseBits-1:0] r_step;
    logic         r_clamp;
    logic [DivBits-1:0]  r_dcnt;
    logic [StepBits-1:0] r_ccnt;
    logic [63:0]  r_x, r_y, r_z;
    logic [63:0]  r_sn, r_cs;
    logic [40:0]  r_px, r_py;
    logic         r_valid;
    logic [1:0]   r_mcnt;
    logic [127:0] r_acc;

    logic [63:0]  mul_a, mul_b;
    logic [31:0]  mul_ah, mul_bh;
    logic [63:0]  mul_pp;
    logic [127:0] mul_sh;
    logic [127:0] mul_p;
    logic         mul_busy;
    logic         mul_last;

    always_comb begin
        mul_a    = 64'd0;
        mul_b    = 64'd0;
        mul_busy = 1'b0;
        unique case (r_state)
            S_MUL_A:   begin
                mul_a = 64'(r_speed); mul_b = 64'(r_dt); mul_busy = 1'b1;
            end
            S_MUL_D:   begin
                mul_a = 64'(r_radius); mul_b = 64'(Kq2000Pi); mul_busy = 1'b1;
            end
            S_MUL_B:   begin
                mul_a = r_prod; mul_b = 64'(r_scale); mul_busy = 1'b1;
            end
            S_ZMUL:    begin
                mul_a = 64'(r_phase[PhaseBits-3:0]); mul_b = PiHalfQ62; mul_busy = 1'b1;
            end
            S_SCALE_X: begin
                mul_a = 64'(r_radius);
                mul_b = r_sn[63] ? (64'd0 - r_sn) : r_sn;
                mul_busy = 1'b1;
            end
            S_SCALE_Y: begin
                mul_a = 64'(r_radius);
                mul_b = r_cs[63] ? (64'd0 - r_cs) : r_cs;
                mul_busy = 1'b1;
            end
            default:   begin mul_a = 64'd0; mul_b = 64'd0; mul_busy = 1'b0; end
        endcase
        mul_ah = r_mcnt[1] ? mul_a[63:32] : mul_a[31:0];
        mul_bh = r_mcnt[0] ? mul_b[63:32] : mul_b[31:0];
        mul_pp = 64'(mul_ah) * 64'(mul_bh);
        unique case (r_mcnt)
            2'd0:    mul_sh = {64'd0, mul_pp};
            2'd3:    mul_sh = {mul_pp, 64'd0};
            default: mul_sh = {32'd0, mul_pp, 32'd0};
        endcase
        mul_p = ((r_mcnt == 2'd0) ? 128'd0 : r_acc) + mul_sh;
    end

    assign mul_last = (r_mcnt == 2'd3);

    function automatic logic [40:0] round_sat(input logic [127:0] p, input logic neg);
        logic [127:0] q;
        logic [65:0]  m;
        logic [39:0]  mag;
        q = p + (128'd1 << 61);
        m = q[127:62];
        mag = (m > 66'(Mask40)) ? Mask40 : m[39:0];
        return neg ? (41'd0 - 41'(mag)) : 41'(mag);
    endfunction

    logic [127:0] rem_sh;
    logic [PhaseBits:0] phase_sum;
    logic [63:0] dx, dy, da;

    assign rem_sh    = {r_rem[126:0], 1'b0};
    assign phase_sum = {1'b0, r_phase} + {1'b0, r_step};
    assign dx        = $signed(r_y) >>> r_ccnt;
    assign dy        = $signed(r_x) >>> r_ccnt;
    assign da        = AtanTab[r_ccnt];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (s_axis_tvalid) n_state = S_MUL_A;
            S_MUL_A:   if (mul_last) n_state = S_MUL_D;
            S_MUL_D:   if (mul_last) n_state = S_MUL_B;
            S_MUL_B:   if (mul_last) n_state = S_CHECK;
            S_CHECK:   n_state = (r_rem >= r_den) ? S_ACC : S_DIV;
            S_DIV:     if (r_dcnt == DivBits'(PhaseBits - 1)) n_state = S_ACC;
            S_ACC:     n_state = S_ZMUL;
            S_ZMUL:    if (mul_last) n_state = S_CORDIC;
            S_CORDIC:  if (r_ccnt == StepBits'(CordicSteps - 1)) n_state = S_QUAD;
            S_QUAD:    n_state = S_SCALE_X;
            S_SCALE_X: if (mul_last) n_state = S_SCALE_Y;
            S_SCALE_Y: if (mul_last) n_state = S_OUT;
            S_OUT:     if (m_axis_tready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {5'd0, r_clamp, r_orbits, r_py, r_px};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_radius <= 40'd384400000;
            r_speed  <= 20'd1022;
            r_scale  <= 24'd59000;
            r_phase  <= '0;
            r_orbits <= 32'd0;
            r_valid  <= 1'b0;
            r_mcnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (mul_busy) r_mcnt <= r_mcnt + 2'd1;
            else r_mcnt <= 2'd0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CfgRadius: r_radius <= i_cfg_data;
                    CfgSpeed:  r_speed  <= i_cfg_data[19:0];
                    CfgScale:  r_scale  <= i_cfg_data[23:0];
                    default:   ;
                endcase
            end
            if (r_state == S_ACC) begin
                r_phase <= phase_sum[PhaseBits-1:0];
                if (phase_sum[PhaseBits]) r_orbits <= r_orbits + 32'd1;
            end
            if (r_state == S_SCALE_Y && mul_last) r_valid <= 1'b1;
            else if (r_state == S_OUT && m_axis_tready) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_busy) r_acc <= mul_p;
        unique case (r_state)
            S_IDLE: if (s_axis_tvalid) r_dt <= s_axis_tdata;
            S_MUL_A: if (mul_last) r_prod <= mul_p[63:0];
            S_MUL_D: if (mul_last) r_den <= mul_p;
            S_MUL_B: if (mul_last) r_rem <= {48'd0, mul_p[63:0], 16'd0};
            S_CHECK: begin
                r_clamp <= (r_rem >= r_den);
                r_step  <= (r_rem >= r_den) ? '1 : '0;
                r_dcnt  <= '0;
            end
            S_DIV: begin
                r_dcnt <= r_dcnt + 1'b1;
                if (rem_sh >= r_den) begin
                    r_rem  <= rem_sh - r_den;
                    r_step <= {r_step[PhaseBits-2:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_step <= {r_step[PhaseBits-2:0], 1'b0};
                end
            end
            S_ZMUL: begin
                if (mul_last) begin
                    r_z    <= 64'(mul_p >> (PhaseBits - 2));
                    r_x    <= CordicGain;
                    r_y    <= 64'd0;
                    r_ccnt <= '0;
                end
            end
            S_CORDIC: begin
                r_ccnt <= r_ccnt + 1'b1;
                if (!r_z[63]) begin
                    r_x <= r_x - dx; r_y <= r_y + dy; r_z <= r_z - da;
                end else begin
                    r_x <= r_x + dx; r_y <= r_y - dy; r_z <= r_z + da;
                end
            end
            S_QUAD: begin
                unique case (r_phase[PhaseBits-1:PhaseBits-2])
                    2'd0:    begin r_sn <= r_y;          r_cs <= r_x;          end
                    2'd1:    begin r_sn <= r_x;          r_cs <= 64'd0 - r_y;  end
                    2'd2:    begin r_sn <= 64'd0 - r_y;  r_cs <= 64'd0 - r_x;  end
                    default: begin r_sn <= 64'd0 - r_x;  r_cs <= r_y;          end
                endcase
            end
            S_SCALE_X: if (mul_last) r_px <= round_sat(mul_p, r_sn[63]);
            S_SCALE_Y: if (mul_last) r_py <= round_sat(mul_p, r_cs[63]);
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_state == S_OUT)) else $error("valid outside output state");
    a_orbit_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ACC) |=> $stable(r_orbits)) else $error("orbit count moved");
`endif

endmodule
`default_nettype wire
